// File: rtl/core/spn_block_cipher_64_macros.svh
// ----------------------------------------------------------------------------
// spn_block_cipher_64 assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SPN_BLOCK_CIPHER_64_MACROS_SVH
`define SPN_BLOCK_CIPHER_64_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SPN64_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SPN64_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SPN64_ASSERT_IMP(lbl, ante, cons, msg)
`define SPN64_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/core/spn64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spn64_pkg
// shared constants, types and helpers of the 64-bit spn block cipher
// ----------------------------------------------------------------------------
package spn64_pkg;

    localparam int ROUNDS      = 16;
    localparam int BLOCK_BYTES = 8;
    localparam int BYTE_W      = 8;
    localparam int BLOCK_W     = BYTE_W * BLOCK_BYTES;
    localparam int KEY_W       = 64;
    localparam int OUT_W       = 64;
    localparam int SEL_W       = 3;
    localparam int OP_W        = 2;
    localparam int IN_DATA_W   = 88;
    localparam int ROUND_W     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);

    // request kinds on the input stream
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_ENC  = 2'd1;
    localparam logic [OP_W-1:0] OP_DEC  = 2'd2;

    // table write towards one bank
    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] index;
        logic [BYTE_W-1:0] value;
    } spn64_wr_t;

    // lookup control shared by all banks
    typedef struct packed {
        logic en;
        logic inv;
    } spn64_rd_t;

    function automatic logic [BLOCK_W-1:0] rot_left(input logic [BLOCK_W-1:0] x);
        return {x[BLOCK_W-2:0], x[BLOCK_W-1]};
    endfunction

    function automatic logic [BLOCK_W-1:0] rot_right(input logic [BLOCK_W-1:0] x);
        return {x[0], x[BLOCK_W-1:1]};
    endfunction

endpackage

// File: rtl/core/spn64_sbox_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spn64_sbox_bank
// forward and inverse substitution memories of one byte lane
// ----------------------------------------------------------------------------
module spn64_sbox_bank (
    input  logic                                 clk,
    input  spn64_pkg::spn64_wr_t                 wr,
    input  spn64_pkg::spn64_rd_t                 rd,
    input  logic [spn64_pkg::BYTE_W-1:0]         rd_addr,
    output logic [spn64_pkg::BYTE_W-1:0]         rd_data
);
    import spn64_pkg::*;

    localparam int DEPTH = 2 ** BYTE_W;

    logic [BYTE_W-1:0] fwd_mem [DEPTH];
    logic [BYTE_W-1:0] inv_mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // a load writes the entry and its mirror in the inverse store
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            fwd_mem[wr.index] <= wr.value;
            inv_mem[wr.value] <= wr.index;
        end
    end

    // registered lookup, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            if (rd.inv)
            begin
                rd_data_reg <= inv_mem[rd_addr];
            end
            else
            begin
                rd_data_reg <= fwd_mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/spn_block_cipher_64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spn_block_cipher_64
// 64-bit substitution-permutation cipher, one round per cycle on shared tables
// a taken block runs its rounds through the lane banks, then is registered
// on the output; a new request is taken only while idle or as the block retires
// one lookup per round in each lane bank; a table load gives no output
// reset clears control, output valid and key; tables hold garbage until loaded
// ----------------------------------------------------------------------------
`include "spn_block_cipher_64_macros.svh"

module spn_block_cipher_64 (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // slave side
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // table_select[2:0], entry_index[10:3], entry_value[18:11], block_in[82:19]
    input  logic [spn64_pkg::IN_DATA_W-1:0]       s_tdata,
    // op[1:0]
    input  logic [spn64_pkg::OP_W-1:0]            s_tuser,
    // master side
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // block_out[63:0]
    output logic [spn64_pkg::OUT_W-1:0]           m_tdata,
    // was_decrypt[0]
    output logic                                  m_tuser,
    // key write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [spn64_pkg::KEY_W-1:0]           cfg_data
);
    import spn64_pkg::*;

    logic [KEY_W-1:0]   key_reg;
    logic               busy_reg;
    logic               busy_next;
    logic [ROUND_W-1:0] round_reg;
    logic [ROUND_W-1:0] round_next;
    logic               dec_reg;
    logic               dec_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [OUT_W-1:0]   out_data_reg;
    logic               out_dec_reg;

    logic [SEL_W-1:0]   in_sel;
    logic [BYTE_W-1:0]  in_index;
    logic [BYTE_W-1:0]  in_value;
    logic [BLOCK_W-1:0] in_block;
    logic [OP_W-1:0]    in_op;

    logic               final_round;
    logic               out_free;
    logic               in_acc;
    logic               start;
    logic               load;
    logic               step;
    logic               retire;

    logic [BLOCK_W-1:0] key_w;
    logic [BLOCK_W-1:0] sub_data;
    logic [BLOCK_W-1:0] enc_out;
    logic [BLOCK_W-1:0] dec_out;
    logic [BLOCK_W-1:0] start_addr;
    logic [BLOCK_W-1:0] cont_addr;
    logic [BLOCK_W-1:0] rd_addr_all;
    logic [BLOCK_W-1:0] result;
    spn64_rd_t          rd;

    // request fields
    assign in_sel   = s_tdata[2:0];
    assign in_index = s_tdata[10:3];
    assign in_value = s_tdata[18:11];
    assign in_block = s_tdata[19 +: BLOCK_W];
    assign in_op    = s_tuser;

    // handshake and round control
    assign final_round = busy_reg && (round_reg == ROUND_LAST);
    assign out_free    = !out_valid_reg || m_tready;
    assign retire      = final_round && out_free;
    assign s_tready    = !busy_reg || retire;
    assign in_acc      = s_tvalid && s_tready;
    assign start       = in_acc && ((in_op == OP_ENC) || (in_op == OP_DEC));
    assign load        = in_acc && (in_op == OP_LOAD);
    assign step        = busy_reg && !final_round;

    // round datapath around the bank outputs
    assign key_w      = key_reg[BLOCK_W-1:0];
    assign enc_out    = rot_left(sub_data);
    assign dec_out    = sub_data ^ key_w;
    assign start_addr = (in_op == OP_DEC) ? rot_right(in_block) : (in_block ^ key_w);
    assign cont_addr  = dec_reg ? rot_right(dec_out) : (enc_out ^ key_w);
    assign rd_addr_all = start ? start_addr : cont_addr;
    assign result     = dec_reg ? dec_out : enc_out;

    assign rd.en  = start || step;
    assign rd.inv = start ? (in_op == OP_DEC) : dec_reg;

    // one bank per byte lane, byte 0 in the top bits
    for (genvar j = 0; j < BLOCK_BYTES; j++)
    begin : g_lane
        localparam int LSB = BLOCK_W - BYTE_W * (j + 1);
        spn64_wr_t wr;

        assign wr.en    = load && (in_sel == SEL_W'(j));
        assign wr.index = in_index;
        assign wr.value = in_value;

        spn64_sbox_bank u_bank (
            .clk     (clk),
            .wr      (wr),
            .rd      (rd),
            .rd_addr (rd_addr_all[LSB +: BYTE_W]),
            .rd_data (sub_data[LSB +: BYTE_W])
        );
    end

    // next control state
    always_comb
    begin
        busy_next      = busy_reg;
        round_next     = round_reg;
        dec_next       = dec_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (retire)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        if (step)
        begin
            round_next = round_reg + 1'b1;
        end
        if (start)
        begin
            busy_next  = 1'b1;
            round_next = '0;
            dec_next   = (in_op == OP_DEC);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            round_reg     <= '0;
            dec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            key_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            round_reg     <= round_next;
            dec_reg       <= dec_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                key_reg <= cfg_data;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            out_data_reg <= OUT_W'(result);
            out_dec_reg  <= dec_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_dec_reg;

    // checks
    `SPN64_ASSERT_NXT(a_start_round0, start, busy_reg && (round_reg == '0), "block did not start at round zero")
    `SPN64_ASSERT_NXT(a_stall_hold, final_round && !out_free, final_round && $stable(sub_data), "finished block lost while output stalled")
    `SPN64_ASSERT_NXT(a_retire_out, retire, out_valid_reg && (out_dec_reg == $past(dec_reg)), "retired block not presented")
    `SPN64_ASSERT_IMP(a_no_read_on_load, load, !rd.en, "table lookup issued with a load")

endmodule

// File: bench/tb_spn_block_cipher_64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spn_block_cipher_64
// self-checking bench for the 64-bit spn block cipher. the tables are first
// loaded as identity permutations, so a short list of directed requests can
// be checked against results typed in by hand. the tables are then reloaded
// with random permutations and several key settings are run with random
// encrypt, decrypt, round-trip and table-swap requests. every result not typed
// in by hand is compared with a mirror of the cipher state kept inside the bench.
// ----------------------------------------------------------------------------
module tb_spn_block_cipher_64;

    import spn64_pkg::*;

    // opcode the block must drop
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    localparam logic [63:0] ONES          = 64'hffff_ffff_ffff_ffff;
    localparam int          CLK_HALF      = 6;
    localparam int          SETTLE_CYCLES = ROUNDS + 4;
    localparam int          LONG_HOLD     = 400;
    localparam int          QUIET_LIMIT   = 2000;
    localparam int          PHASE_ITEMS   = 150;
    localparam int          NUM_PHASES    = 6;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SEL_W-1:0]   tsel;
        logic [7:0]         idx;
        logic [7:0]         val;
        logic [63:0]        blk;
        logic               known;
        logic [63:0]        result;
    } stim_row_t;

    typedef struct packed {
        logic [63:0] blk;
        logic        dec;
    } cipher_result_t;

    // directed requests, identity tables and a zero key at the start
    localparam int DIR_ROWS = 16;
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        // identity tables with zero key: sixteen one-bit rotations
        '{OP_ENC,  3'd0, 8'h00, 8'h00, 64'h0,                   1'b1, 64'h0},
        '{OP_ENC,  3'd7, 8'hff, 8'hff, ONES,                    1'b1, ONES},
        '{OP_DEC,  3'd0, 8'h00, 8'h00, 64'h0,                   1'b1, 64'h0},
        '{OP_DEC,  3'd7, 8'hff, 8'hff, ONES,                    1'b1, ONES},
        '{OP_ENC,  3'd1, 8'h01, 8'h02, 64'h1,                   1'b1, 64'h1_0000},
        '{OP_DEC,  3'd2, 8'h03, 8'h04, 64'h1_0000,              1'b1, 64'h1},
        '{OP_ENC,  3'd3, 8'h80, 8'h7f, 64'h8000_0000_0000_0000, 1'b1, 64'h8000},
        '{OP_DEC,  3'd4, 8'h7f, 8'h80, 64'h8000,                1'b1,
          64'h8000_0000_0000_0000},
        // unused opcode is dropped
        '{OP_NONE, 3'd5, 8'haa, 8'h55, 64'hdead_beef_0bad_f00d, 1'b0, 64'h0},
        // loads that break the permutation of the outer tables
        '{OP_LOAD, 3'd7, 8'hff, 8'h00, ONES,                    1'b0, 64'h0},
        '{OP_LOAD, 3'd0, 8'h00, 8'hff, 64'h0,                   1'b0, 64'h0},
        '{OP_ENC,  3'd0, 8'h00, 8'h00, 64'h0123_4567_89ab_cdef, 1'b0, 64'h0},
        '{OP_DEC,  3'd0, 8'h00, 8'h00, 64'hfedc_ba98_7654_3210, 1'b0, 64'h0},
        '{OP_ENC,  3'd6, 8'h11, 8'h22, ONES,                    1'b0, 64'h0},
        '{OP_DEC,  3'd6, 8'h33, 8'h44, 64'h0,                   1'b0, 64'h0},
        '{OP_LOAD, 3'd3, 8'h5a, 8'ha5, 64'h5555_aaaa_5555_aaaa, 1'b0, 64'h0}
    };

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata   = '0;
    logic [OP_W-1:0]      s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [KEY_W-1:0]     cfg_data  = '0;

    // mirror of the cipher state
    logic [7:0]           fwd_tab [8][256];
    logic [7:0]           inv_tab [8][256];
    logic [63:0]          key_mirror = 64'h0;

    cipher_result_t       pending_results [$];
    int                   mismatches  = 0;
    int                   quiet_cycles = 0;
    bit                   tx_idle_on  = 1'b1;
    bit                   rx_idle_on  = 1'b1;
    bit                   long_hold   = 1'b0;

    spn_block_cipher_64 DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // byte j through table j, byte 0 in the top bits
    function automatic logic [63:0] substitute_bytes(input logic [63:0] x, input bit inv);
        logic [63:0] r;
        logic [7:0]  b;
        int          sh;
        r = '0;
        for (int j = 0; j < 8; j++)
        begin
            sh = 8 * (7 - j);
            b  = x[sh +: 8];
            r[sh +: 8] = inv ? inv_tab[j][b] : fwd_tab[j][b];
        end
        return r;
    endfunction

    function automatic logic [63:0] encipher_block(input logic [63:0] x);
        logic [63:0] s;
        for (int r = 0; r < ROUNDS; r++)
        begin
            s = substitute_bytes(x ^ key_mirror, 1'b0);
            x = {s[62:0], s[63]};
        end
        return x;
    endfunction

    function automatic logic [63:0] decipher_block(input logic [63:0] x);
        for (int r = 0; r < ROUNDS; r++)
            x = substitute_bytes({x[0], x[63:1]}, 1'b1) ^ key_mirror;
        return x;
    endfunction

    function automatic logic [63:0] rand_block();
        case ($urandom_range(0, 9))
            0:       return 64'h0;
            1:       return ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // offer one request and update the mirror once it is taken
    task automatic send_item(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] tsel,
                             input logic [7:0] idx, input logic [7:0] val,
                             input logic [63:0] blk, input bit known,
                             input logic [63:0] known_blk);
        cipher_result_t res;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, blk, val, idx, tsel};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        case (op)
            OP_LOAD:
            begin
                fwd_tab[tsel][idx] = val;
                inv_tab[tsel][val] = idx;
            end
            OP_ENC:
            begin
                res.blk = known ? known_blk : encipher_block(blk);
                res.dec = 1'b0;
                pending_results.push_back(res);
            end
            OP_DEC:
            begin
                res.blk = known ? known_blk : decipher_block(blk);
                res.dec = 1'b1;
                pending_results.push_back(res);
            end
            default: ;
        endcase
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // stop offering, wait for all results, then let a load finish
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_key(input logic [63:0] k);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        key_mirror = k;
        cfg_valid <= 1'b0;
    endtask

    // fill every table with a permutation, identity or shuffled
    task automatic load_tables(input bit shuffled);
        logic [7:0] perm [256];
        logic [7:0] tmp;
        int         k;
        for (int t = 0; t < 8; t++)
        begin
            for (int i = 0; i < 256; i++)
                perm[i] = 8'(i);
            if (shuffled)
            begin
                for (int i = 255; i > 0; i--)
                begin
                    k       = $urandom_range(0, i);
                    tmp     = perm[i];
                    perm[i] = perm[k];
                    perm[k] = tmp;
                end
            end
            for (int i = 0; i < 256; i++)
                send_item(OP_LOAD, 3'(t), 8'(i), perm[i], {$urandom, $urandom}, 1'b0, 64'h0);
        end
    endtask

    // random mix of blocks, round trips, table swaps, single loads and dropped opcodes
    task automatic run_random(input int n_items, input bit with_pressure);
        int          sent;
        int          pick;
        logic [2:0]  t;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  va;
        logic [7:0]  vb;
        sent = 0;
        // receiver holds off while encrypt requests keep coming
        if (with_pressure)
        begin
            long_hold = 1'b1;
            repeat (20)
            begin
                send_item(OP_ENC, 3'($urandom), 8'($urandom), 8'($urandom),
                          rand_block(), 1'b0, 64'h0);
                sent++;
            end
        end
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            t    = 3'($urandom);
            a    = 8'($urandom);
            b    = 8'($urandom);
            if (pick < 50)
            begin
                send_item(OP_ENC, t, a, b, rand_block(), 1'b0, 64'h0);
                sent++;
            end
            else if (pick < 62)
            begin
                // decrypt what the current tables make of a random block
                send_item(OP_DEC, t, a, b, encipher_block(rand_block()), 1'b0, 64'h0);
                sent++;
            end
            else if (pick < 75)
            begin
                send_item(OP_DEC, t, a, b, rand_block(), 1'b0, 64'h0);
                sent++;
            end
            else if (pick < 90)
            begin
                // swap two entries so the table stays a permutation
                va = fwd_tab[t][a];
                vb = fwd_tab[t][b];
                send_item(OP_LOAD, t, a, vb, rand_block(), 1'b0, 64'h0);
                send_item(OP_LOAD, t, b, va, rand_block(), 1'b0, 64'h0);
                sent += 2;
            end
            else if (pick < 95)
            begin
                send_item(OP_LOAD, t, a, b, rand_block(), 1'b0, 64'h0);
                sent++;
            end
            else
                send_item(OP_NONE, t, a, b, rand_block(), 1'b0, 64'h0);
        end
    endtask

    // receiver with random hold-offs and one long stall on demand
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        cipher_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", m_tdata, 64'h0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.blk)
                    report_mismatch("block_out", m_tdata, want.blk);
                if (m_tuser !== want.dec)
                    report_mismatch("was_decrypt", 64'(m_tuser), 64'(want.dec));
            end
        end
    end

    // watchdog on cycles with no request taken anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("spn_block_cipher_64 test failed");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        logic [63:0] phase_key;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_tables(1'b0);
        for (int r = 0; r < DIR_ROWS; r++)
            send_item(DIRECTED[r].op, DIRECTED[r].tsel, DIRECTED[r].idx, DIRECTED[r].val,
                      DIRECTED[r].blk, DIRECTED[r].known, DIRECTED[r].result);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       phase_key = ONES;
                1:       phase_key = 64'h0;
                2:       phase_key = 64'h8000_0000_0000_0001;
                default: phase_key = {$urandom, $urandom};
            endcase
            write_key(phase_key);
            if (p == 0)
                load_tables(1'b1);
            // last phase runs flat out on both sides
            if (p == NUM_PHASES - 1)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            run_random(PHASE_ITEMS, p == 1);
            drain();
        end

        if (mismatches == 0)
            $display("spn_block_cipher_64 test passed");
        else
            $display("spn_block_cipher_64 test failed");
        $finish;
    end

endmodule
